@@ rtl/brle_pkg.sv @@
// ============================================================================
// brle_pkg
// Shared types and constants for the backward run-length unpacker.
// ============================================================================
package brle_pkg;

  // Stream byte and field widths
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 20;

  // Record decoding constants
  localparam logic [BYTE_W-1:0]  PAD_BYTE  = 8'hFF;
  localparam logic [BYTE_W-1:0]  KIND_MASK = 8'hFE;
  localparam logic [BYTE_W-1:0]  OP_FILL   = 8'hB0;
  localparam logic [BYTE_W-1:0]  OP_COPY   = 8'hB2;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

  // Capacity after reset: 65535 paragraphs of 16 bytes
  localparam logic [TOTAL_W-1:0] CAPACITY_RESET = 20'd1048560;

  // Decoder phases
  typedef enum logic [2:0] {
    PH_PAD  = 3'd0,
    PH_OPC  = 3'd1,
    PH_CHI  = 3'd2,
    PH_CLO  = 3'd3,
    PH_FILL = 3'd4,
    PH_COPY = 3'd5,
    PH_TAIL = 3'd6
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // One result word
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] repeat_count;
    status_t            status;
    logic               overflow;
    logic               end_of_stream;
    logic [TOTAL_W-1:0] total_bytes;
  } result_t;

endpackage

@@ rtl/backward_rle_unpacker.sv @@
// ============================================================================
// backward_rle_unpacker
// Streaming decoder for backward run-length packed images: skips padding,
// decodes fill and copy records, passes the tail through and reports totals.
// ============================================================================
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: packed_byte; s_tlast: last_byte
//  m_*      | out | m_tvalid/m_tready  | m_tdata/m_tuser (see ports); m_tlast: end
//  cfg_*    | in  | cfg_we             | cfg_wdata: capacity_bytes
//
//  One packed byte per cycle while s_tready is high; the decoder output is
//  combinational and each word is registered in the two-entry result buffer.
//  s_tready drops only while both buffer entries hold unread words.
//  rst is synchronous: clears the stream state and sets capacity to 1048560.
//  m_tready low stalls only the buffer; input keeps flowing until it fills.
//
module backward_rle_unpacker (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,   // capacity_bytes
  // packed input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] packed_byte
  input  logic        s_tlast,     // last_byte
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,     // [7:0] out_byte, [23:8] repeat_count,
                                   // [43:24] total_bytes, [47:44] zero
  output logic [2:0]  m_tuser,     // [1:0] status, [2] overflow
  output logic        m_tlast      // end_of_stream
);
  import brle_pkg::*;

  logic    in_valid;
  logic    res_valid;
  result_t res;
  result_t head;
  logic    space;

  assign s_tready = space;
  assign in_valid = s_tvalid && s_tready;

  brle_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  brle_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  // Output word packing
  assign m_tdata = {4'b0000, head.total_bytes, head.repeat_count, head.out_byte};
  assign m_tuser = {head.overflow, head.status};
  assign m_tlast = head.end_of_stream;

endmodule

@@ rtl/brle_decoder.sv @@
// ============================================================================
// brle_decoder
// Record decoder: phase register, held opcode, run length and output total,
// plus the capacity register (cfg_we). One accepted byte updates all but capacity.
// ============================================================================
module brle_decoder (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [brle_pkg::TOTAL_W-1:0] cfg_wdata,
  input  logic                    in_valid,
  input  logic [brle_pkg::BYTE_W-1:0]  in_byte,
  input  logic                    in_last,
  output logic                    res_valid,
  output brle_pkg::result_t       res
);
  import brle_pkg::*;

  phase_t               phase, phase_next;
  logic [BYTE_W-1:0]    held_opcode, held_opcode_next;
  logic [COUNT_W-1:0]   run_length, run_length_next;
  logic [TOTAL_W-1:0]   total, total_next;
  logic                 saturated, saturated_next;
  logic [TOTAL_W-1:0]   capacity;

  logic                 emit;
  logic                 add_en;
  logic [COUNT_W-1:0]   add_n;
  logic [TOTAL_W:0]     sum;
  logic [BYTE_W-1:0]    kind;
  phase_t               finish_phase;
  status_t              st;
  logic [BYTE_W-1:0]    ob;
  logic [COUNT_W-1:0]   rep;
  logic                 trunc;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Phase decode for one byte
  always_comb begin
    phase_next       = phase;
    held_opcode_next = held_opcode;
    run_length_next  = run_length;
    emit             = 1'b0;
    add_en           = 1'b0;
    add_n            = '0;
    st               = ST_OK;
    ob               = '0;
    rep              = '0;
    kind             = held_opcode & KIND_MASK;
    finish_phase     = held_opcode[0] ? PH_TAIL : PH_OPC;

    unique case (phase)
      PH_OPC: begin
        held_opcode_next = in_byte;
        phase_next       = PH_CHI;
      end
      PH_CHI: begin
        run_length_next = {in_byte, {BYTE_W{1'b0}}};
        phase_next      = PH_CLO;
      end
      PH_CLO: begin
        run_length_next = {run_length[COUNT_W-1:BYTE_W], in_byte};
        if (kind == OP_FILL) begin
          phase_next = PH_FILL;
        end else if (kind == OP_COPY) begin
          phase_next = (run_length_next == '0) ? finish_phase : PH_COPY;
        end else begin
          emit       = 1'b1;
          st         = ST_UNKNOWN;
          phase_next = finish_phase;
        end
      end
      PH_FILL: begin
        if (run_length != '0) begin
          ob     = in_byte;
          rep    = run_length;
          add_en = 1'b1;
          add_n  = run_length;
          emit   = 1'b1;
        end
        run_length_next = '0;
        phase_next      = finish_phase;
      end
      PH_COPY: begin
        ob              = in_byte;
        rep             = COUNT_W'(1);
        add_en          = 1'b1;
        add_n           = COUNT_W'(1);
        emit            = 1'b1;
        run_length_next = run_length - COUNT_W'(1);
        if (run_length_next == '0) begin
          phase_next = finish_phase;
        end
      end
      PH_TAIL: begin
        ob     = in_byte;
        rep    = COUNT_W'(1);
        add_en = 1'b1;
        add_n  = COUNT_W'(1);
        emit   = 1'b1;
      end
      default: begin
        // padding skip; also covers the unused phase code
        if (in_byte != PAD_BYTE) begin
          held_opcode_next = in_byte;
          phase_next       = PH_CHI;
        end else begin
          phase_next = PH_PAD;
        end
      end
    endcase

    // Saturating output total
    sum            = {1'b0, total} + {{(TOTAL_W + 1 - COUNT_W){1'b0}}, add_n};
    total_next     = total;
    saturated_next = saturated;
    if (add_en) begin
      if (sum[TOTAL_W]) begin
        total_next     = TOTAL_MAX;
        saturated_next = 1'b1;
      end else begin
        total_next = sum[TOTAL_W-1:0];
      end
    end

    // End of stream inside a record
    trunc = (phase_next == PH_CHI) || (phase_next == PH_CLO) ||
            (phase_next == PH_FILL) || (phase_next == PH_COPY);
    if (in_last) begin
      emit = 1'b1;
      if (trunc) begin
        st = ST_TRUNC;
      end
    end
  end

  // Result word
  always_comb begin
    res_valid         = in_valid && emit;
    res.out_byte      = ob;
    res.repeat_count  = rep;
    res.status        = st;
    res.overflow      = saturated_next || (total_next > capacity);
    res.end_of_stream = in_last;
    res.total_bytes   = total_next;
  end

  // Decoder state; the final byte returns it to reset
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PAD;
      held_opcode <= '0;
      run_length  <= '0;
      total       <= '0;
      saturated   <= 1'b0;
    end else if (in_valid) begin
      if (in_last) begin
        phase       <= PH_PAD;
        held_opcode <= '0;
        run_length  <= '0;
        total       <= '0;
        saturated   <= 1'b0;
      end else begin
        phase       <= phase_next;
        held_opcode <= held_opcode_next;
        run_length  <= run_length_next;
        total       <= total_next;
        saturated   <= saturated_next;
      end
    end
  end

  // Final byte always yields a word and clears the stream
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_last |-> res_valid)
    else $error("final byte produced no word");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_last |=> phase == PH_PAD && total == '0 && !saturated)
    else $error("stream state not cleared after final byte");

  a_trunc_only_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_TRUNC |-> res.end_of_stream)
    else $error("truncation status on a word that is not the last");

  a_total_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !in_valid |=> $stable(total) && $stable(phase))
    else $error("decoder state moved without an accepted byte");

endmodule

@@ rtl/brle_out_buf.sv @@
// ============================================================================
// brle_out_buf
// Two-entry result buffer between the decoder and the output stream; lets a
// new byte be taken while a finished word still waits.
// ============================================================================
module brle_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  brle_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output brle_pkg::result_t out_data
);
  import brle_pkg::*;

  result_t     entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign out_data  = entry[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2 || pop)
    else $error("word pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("buffer count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("pointers disagree with fill count");

endmodule
